>>> hw/rtl/rss_pkg.sv
// Package for the instruction step core: field widths, decode constants, opcodes.
// No dependencies.
`timescale 1ns / 1ps

package rss_pkg;

    localparam int unsigned DataWordsDefault = 1024;
    localparam int unsigned InWidth          = 80;   // op, instr_word, load_index, load_value
    localparam int unsigned OutWidth         = 264;  // 262 bits of fields, zero filled

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_EXEC  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    localparam logic [23:0] BX_PATTERN = 24'h12FFF1;
    localparam logic [3:0]  DP_ADD = 4'b0100;
    localparam logic [3:0]  DP_SUB = 4'b0010;
    localparam logic [3:0]  DP_CMP = 4'b1010;
    localparam logic [3:0]  DP_MOV = 4'b1101;
    localparam logic [3:0]  CC_EQ  = 4'b0000;
    localparam logic [3:0]  CC_NE  = 4'b0001;
    localparam logic [3:0]  CC_GT  = 4'b1100;
    localparam logic [3:0]  CC_AL  = 4'b1110;
    localparam logic [2:0]  BR_CLASS = 3'b101;

    localparam logic [2:0] CFG_ARG0  = 3'd0;
    localparam logic [2:0] CFG_ARG1  = 3'd1;
    localparam logic [2:0] CFG_ARG2  = 3'd2;
    localparam logic [2:0] CFG_ARG3  = 3'd3;
    localparam logic [2:0] CFG_ENTRY = 3'd4;

    localparam logic [3:0] REG_SP = 4'd13;
    localparam logic [3:0] REG_LR = 4'd14;

    // Result of one step, toward the output register
    typedef struct packed {
        logic [31:0] not_taken_total;
        logic [31:0] taken_total;
        logic [31:0] branch_total;
        logic [31:0] memory_count;
        logic [31:0] alu_count;
        logic [31:0] total_count;
        logic        undefined_instr;
        logic        halted;
        logic [3:0]  flag_bits;
        logic [31:0] result_value;
        logic [31:0] next_pc;
    } step_result_t;

endpackage

>>> hw/rtl/rss_dmem.sv
// Data memory: synchronous RAM, one write and one registered read per cycle.
// Depends on nothing but its parameter.
`timescale 1ns / 1ps

module rss_dmem #(
    parameter int unsigned DATA_WORDS = 1024
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DATA_WORDS)-1:0] waddr,
    input  logic [31:0]                   wdata,
    input  logic [$clog2(DATA_WORDS)-1:0] raddr,
    output logic [31:0]                   rdata
);

    logic [31:0] mem [DATA_WORDS];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

>>> hw/rtl/risc_subset_instruction_step.sv
// Top level of the instruction step core; uses rss_pkg and rss_dmem.
// Holds register file, flags, counters and the step sequencer.
`timescale 1ns / 1ps
//
// Usage: each transfer on s_axis carries op (start, execute, write data word);
// exactly one result transfer follows on m_axis with the pc, register 0, the
// flags, halt and undefined marks and six event counters.
// Configuration (arguments and entry address) is written on cfg_we/cfg_index/
// cfg_data while the core is idle.
// Timing: the input transfer edge issues the data memory read at the effective
// address; a later edge, once the output register is free, applies the
// read-modify-write and registers the result in the output register. Input is
// not ready while an item sits in the issue stage, so a new item is taken only
// after the last one has left it, as the data memory read is registered.
// Reset: after rst_n falls the core is not ready while a clearing pass walks
// all DATA_WORDS words of the data memory; registers, flags and counters clear
// at once. A stalled receiver holds the result in the output register; one
// further item may be taken and held in the issue stage, then input stalls
// until the output register empties.

module risc_subset_instruction_step #(
    parameter int unsigned DATA_WORDS = rss_pkg::DataWordsDefault
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // op[1:0], instr_word[33:2], load_index[43:34], load_value[75:44], zeros
    input  logic [rss_pkg::InWidth-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // next_pc[31:0], result_value[63:32], flag_bits[67:64], halted[68],
    // undefined_instr[69], total_count[101:70], alu_count[133:102],
    // memory_count[165:134], branch_total[197:166], taken_total[229:198],
    // not_taken_total[261:230], zeros
    output logic [rss_pkg::OutWidth-1:0]  m_axis_tdata,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);

    localparam int unsigned AW = $clog2(DATA_WORDS);

    // configuration
    logic [31:0] arg_reg [4];
    logic [31:0] entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            arg_reg[0] <= '0;
            arg_reg[1] <= '0;
            arg_reg[2] <= '0;
            arg_reg[3] <= '0;
            entry_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rss_pkg::CFG_ARG0:  arg_reg[0] <= cfg_data;
                rss_pkg::CFG_ARG1:  arg_reg[1] <= cfg_data;
                rss_pkg::CFG_ARG2:  arg_reg[2] <= cfg_data;
                rss_pkg::CFG_ARG3:  arg_reg[3] <= cfg_data;
                rss_pkg::CFG_ENTRY: entry_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // architectural state
    logic [31:0] rf_reg [16];
    logic [3:0]  flags_reg;
    logic [31:0] cnt_total_reg, cnt_alu_reg, cnt_mem_reg;
    logic [31:0] cnt_br_reg, cnt_tk_reg, cnt_nt_reg;

    // sequencing: clearing pass, issue stage (held item), output register
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;
    logic          busy_reg;
    logic [1:0]    op_reg;
    logic [31:0]   iw_reg;
    logic [AW-1:0] widx_reg;
    logic [31:0]   wval_reg;
    logic [31:0]   addr_reg;
    logic          out_valid_reg;
    rss_pkg::step_result_t out_reg;

    // one item in flight: the issue stage takes a new item only when empty
    logic in_fire, out_free, done;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign done          = busy_reg && out_free;
    assign s_axis_tready = !clr_busy_reg && !busy_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    // input fields
    logic [1:0]  in_op;
    logic [31:0] in_iw, in_val;
    logic [9:0]  in_idx;
    assign in_op  = s_axis_tdata[1:0];
    assign in_iw  = s_axis_tdata[33:2];
    assign in_idx = s_axis_tdata[43:34];
    assign in_val = s_axis_tdata[75:44];

    // address of a memory instruction, computed at issue (state is final then)
    logic [31:0] iss_off, iss_addr;
    assign iss_off  = in_iw[25] ? rf_reg[in_iw[3:0]] : {20'd0, in_iw[11:0]};
    assign iss_addr = rf_reg[in_iw[19:16]] + iss_off;

    // data memory
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [31:0]   mem_wdata, mem_rdata;

    rss_dmem #(.DATA_WORDS(DATA_WORDS)) u_dmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );
    // held item keeps its read address so the read data survives a stall
    assign mem_raddr = busy_reg ? addr_reg[AW+1:2] : iss_addr[AW+1:2];

    // execute stage decode
    logic [3:0]  rd, rn, rm, rs, mrd;
    logic [3:0]  opcode, cond;
    logic        is_bx, is_mul, is_dp, is_br, is_mem, run;
    assign rd     = iw_reg[15:12];
    assign rn     = iw_reg[19:16];
    assign rm     = iw_reg[3:0];
    assign rs     = iw_reg[11:8];
    assign mrd    = iw_reg[19:16];
    assign opcode = iw_reg[24:21];
    assign cond   = iw_reg[31:28];
    assign run    = (op_reg == rss_pkg::OP_EXEC) && (rf_reg[15] != 32'd0);
    assign is_bx  = iw_reg[27:4] == rss_pkg::BX_PATTERN;
    assign is_mul = !is_bx && (iw_reg[27:21] == 7'd0);
    assign is_dp  = !is_bx && !is_mul && (iw_reg[27:26] == 2'b00);
    assign is_br  = !is_bx && !is_mul && !is_dp && (iw_reg[27:25] == rss_pkg::BR_CLASS);
    assign is_mem = !is_bx && !is_mul && !is_dp && !is_br && (iw_reg[27:26] == 2'b01);

    logic [31:0] op2, a_val, diff, product;
    assign op2     = iw_reg[25] ? {24'd0, iw_reg[7:0]} : rf_reg[rm];
    assign a_val   = rf_reg[rn];
    assign diff    = a_val - op2;
    assign product = rf_reg[rs] * rf_reg[rm];

    logic cond_ok;
    always_comb
    begin
        unique case (cond)
            rss_pkg::CC_EQ: cond_ok = flags_reg[2];
            rss_pkg::CC_NE: cond_ok = !flags_reg[2];
            rss_pkg::CC_GT: cond_ok = !flags_reg[2] && (flags_reg[3] == flags_reg[0]);
            rss_pkg::CC_AL: cond_ok = 1'b1;
            default:        cond_ok = 1'b0;
        endcase
    end

    // cmp flags, kept as specified
    logic [3:0] cmp_flags;
    logic a_neg, b_neg, r_neg, a_pos, b_pos, r_pos;
    always_comb
    begin
        a_neg = a_val[31];
        b_neg = op2[31];
        r_neg = diff[31];
        a_pos = !a_neg && (a_val != 32'd0);
        b_pos = !b_neg && (op2 != 32'd0);
        r_pos = !r_neg && (diff != 32'd0);
        cmp_flags = {r_neg, diff == 32'd0, op2 > a_val,
                     (a_pos && b_neg && r_neg) || (a_neg && b_pos && r_pos)};
    end

    // memory lane access
    logic [1:0]  lane;
    logic [31:0] ld_val, st_word;
    logic [4:0]  sh;
    assign lane    = addr_reg[1:0];
    assign sh      = {lane, 3'b000};
    assign ld_val  = iw_reg[22] ? ((mem_rdata >> sh) & 32'hFF) : mem_rdata;
    assign st_word = iw_reg[22]
        ? ((mem_rdata & ~(32'hFF << sh)) | ({24'd0, rf_reg[rd][7:0]} << sh))
        : rf_reg[rd];

    // execute: register, flag and counter updates, memory write-back
    logic [31:0] rf_next [16];
    logic [3:0]  flags_next;
    logic [31:0] tot_next, alu_next, mem_next, br_next, tk_next, nt_next;
    logic        undef_next;
    logic [31:0] boff;
    always_comb
    begin
        for (int i = 0; i < 16; i++)
        begin
            rf_next[i] = rf_reg[i];
        end
        flags_next = flags_reg;
        tot_next   = cnt_total_reg;
        alu_next   = cnt_alu_reg;
        mem_next   = cnt_mem_reg;
        br_next    = cnt_br_reg;
        tk_next    = cnt_tk_reg;
        nt_next    = cnt_nt_reg;
        undef_next = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg[AW+1:2];
        mem_wdata  = st_word;
        boff       = {{6{iw_reg[23]}}, iw_reg[23:0], 2'b00} + 32'd8;
        if (clr_busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else if (busy_reg && done)
        begin
            unique case (op_reg)
                rss_pkg::OP_START:
                begin
                    for (int i = 0; i < 16; i++)
                    begin
                        rf_next[i] = '0;
                    end
                    rf_next[0] = arg_reg[0];
                    rf_next[1] = arg_reg[1];
                    rf_next[2] = arg_reg[2];
                    rf_next[3] = arg_reg[3];
                    rf_next[rss_pkg::REG_SP] = 32'(DATA_WORDS * 4);
                    rf_next[15] = entry_reg;
                    flags_next = '0;
                    tot_next = '0; alu_next = '0; mem_next = '0;
                    br_next = '0; tk_next = '0; nt_next = '0;
                end
                rss_pkg::OP_WRITE:
                begin
                    mem_we    = 1'b1;
                    mem_waddr = widx_reg;
                    mem_wdata = wval_reg;
                end
                rss_pkg::OP_EXEC:
                begin
                    if (run)
                    begin
                        priority if (is_bx)
                        begin
                            rf_next[15] = rf_reg[rm];
                            br_next = cnt_br_reg + 1;
                            tk_next = cnt_tk_reg + 1;
                            tot_next = cnt_total_reg + 1;
                        end
                        else if (is_mul)
                        begin
                            rf_next[mrd] = product;
                            if (mrd != 4'd15) rf_next[15] = rf_reg[15] + 32'd4;
                            alu_next = cnt_alu_reg + 1;
                            tot_next = cnt_total_reg + 1;
                        end
                        else if (is_dp)
                        begin
                            unique case (opcode)
                                rss_pkg::DP_ADD: rf_next[rd] = a_val + op2;
                                rss_pkg::DP_SUB: rf_next[rd] = diff;
                                rss_pkg::DP_CMP: flags_next = cmp_flags;
                                rss_pkg::DP_MOV: rf_next[rd] = op2;
                                default: ;
                            endcase
                            if (rd != 4'd15) rf_next[15] = rf_reg[15] + 32'd4;
                            alu_next = cnt_alu_reg + 1;
                            tot_next = cnt_total_reg + 1;
                        end
                        else if (is_br)
                        begin
                            if (cond_ok)
                            begin
                                if (iw_reg[24]) rf_next[rss_pkg::REG_LR] = rf_reg[15] + 32'd4;
                                rf_next[15] = rf_reg[15] + boff;
                                tk_next = cnt_tk_reg + 1;
                            end
                            else
                            begin
                                rf_next[15] = rf_reg[15] + 32'd4;
                                nt_next = cnt_nt_reg + 1;
                            end
                            br_next = cnt_br_reg + 1;
                            tot_next = cnt_total_reg + 1;
                        end
                        else if (is_mem)
                        begin
                            if (iw_reg[20])
                            begin
                                rf_next[rd] = ld_val;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                            end
                            if (rd != 4'd15) rf_next[15] = rf_reg[15] + 32'd4;
                            mem_next = cnt_mem_reg + 1;
                            tot_next = cnt_total_reg + 1;
                        end
                        else
                        begin
                            undef_next = 1'b1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                rf_reg[i] <= '0;
            end
            flags_reg     <= '0;
            cnt_total_reg <= '0;
            cnt_alu_reg   <= '0;
            cnt_mem_reg   <= '0;
            cnt_br_reg    <= '0;
            cnt_tk_reg    <= '0;
            cnt_nt_reg    <= '0;
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < 16; i++)
            begin
                rf_reg[i] <= rf_next[i];
            end
            flags_reg     <= flags_next;
            cnt_total_reg <= tot_next;
            cnt_alu_reg   <= alu_next;
            cnt_mem_reg   <= mem_next;
            cnt_br_reg    <= br_next;
            cnt_tk_reg    <= tk_next;
            cnt_nt_reg    <= nt_next;
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == AW'(DATA_WORDS - 1)) clr_busy_reg <= 1'b0;
            end
            if (in_fire)
            begin
                busy_reg <= 1'b1;
            end
            else if (done)
            begin
                busy_reg <= 1'b0;
            end
            if (done)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg   <= in_op;
            iw_reg   <= in_iw;
            widx_reg <= AW'(in_idx);
            wval_reg <= in_val;
            addr_reg <= iss_addr;
        end
        if (done)
        begin
            out_reg.next_pc         <= rf_next[15];
            out_reg.result_value    <= rf_next[0];
            out_reg.flag_bits       <= flags_next;
            out_reg.halted          <= rf_next[15] == 32'd0;
            out_reg.undefined_instr <= undef_next;
            out_reg.total_count     <= tot_next;
            out_reg.alu_count       <= alu_next;
            out_reg.memory_count    <= mem_next;
            out_reg.branch_total    <= br_next;
            out_reg.taken_total     <= tk_next;
            out_reg.not_taken_total <= nt_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {2'b00, out_reg};

    // checks
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !s_axis_tready)
        else $error("input taken during clearing pass");
    a_done_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> m_axis_tvalid)
        else $error("finished item not shown");
    a_undef_exec_only: assert property (@(posedge clk) disable iff (!rst_n)
        (done && undef_next) |-> (op_reg == rss_pkg::OP_EXEC))
        else $error("undefined mark outside execute");
    a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(out_reg))
        else $error("result changed while stalled");
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !s_axis_tready)
        else $error("input taken while an item is held");

endmodule
